FILE: rtl/core/telemetry_point_frame_grouper_defines.svh
// ---------------------------------------------------------------------------
// telemetry point frame grouper assertion macros
// shared check wrappers, clocked on clk and disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef TELEMETRY_POINT_FRAME_GROUPER_DEFINES_SVH
`define TELEMETRY_POINT_FRAME_GROUPER_DEFINES_SVH

// same-cycle implication
`define TPFG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpfg same-cycle check failed");

// next-cycle implication
`define TPFG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpfg next-cycle check failed");

`endif

FILE: rtl/core/tpfg_pkg.sv
// ---------------------------------------------------------------------------
// tpfg_pkg
// types, constants and helpers shared by the frame grouper modules
// ---------------------------------------------------------------------------
`default_nettype none

package tpfg_pkg;

  localparam int ADDR_W      = 24;
  localparam int IDX_OUT_W   = 16;
  localparam int MAX_W       = 8;
  localparam int IO_W        = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int OUT_TDATA_W = 48;
  localparam int SLOTS       = 3;

  // frame overhead and per-object address bytes
  localparam int HDR_BYTES  = 6;
  localparam int ADDR_BYTES = 3;

  localparam int MAX_ASDU_RST = 249;
  localparam int IO_SIZE_RST  = 8;
  localparam int SEQ_LIMIT_RST =
    (MAX_ASDU_RST - HDR_BYTES - IO_SIZE_RST) / (IO_SIZE_RST - ADDR_BYTES) + 1;

  localparam int MAX_POINTS_DEF = 65536;

  // one quotient bit per step of the limit divider
  localparam int DIV_STEPS = MAX_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ASDU = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_IO_SIZE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]    ioa_res;
    logic [IDX_OUT_W-1:0] point_index;
    logic                 sequence_mode;
    logic                 first_in_frame;
    logic                 last_in_frame;
    logic                 results_end;
  } result_t;

  typedef struct packed {
    result_t [SLOTS-1:0] slot;
    logic    [1:0]       cnt;
  } batch_t;

  typedef struct packed {
    logic [MAX_W-1:0] seq_limit;
    logic             plain_single;
  } lim_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic [MAX_W-1:0] fill_next;
  } seq_mark_t;

  // place one object in the open sequence frame
  function automatic seq_mark_t seq_mark(input logic [MAX_W-1:0] fill,
                                         input logic run_end,
                                         input logic [MAX_W-1:0] limit);
    seq_mark_t m;
    logic [MAX_W-1:0] bumped;
    bumped      = fill + 1'b1;
    m.first     = (fill == '0);
    m.last      = run_end || (bumped >= limit);
    m.fill_next = m.last ? '0 : bumped;
    return m;
  endfunction

  function automatic result_t mk_result(input logic [ADDR_W-1:0] addr,
                                        input logic seq,
                                        input logic first,
                                        input logic last);
    result_t r;
    r.ioa_res        = addr;
    r.point_index    = '0;
    r.sequence_mode  = seq;
    r.first_in_frame = first;
    r.last_in_frame  = last;
    r.results_end    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tpfg_limits.sv
// ---------------------------------------------------------------------------
// tpfg_limits
// frame size limits from the configuration, sequence quotient by a serial divider
// ---------------------------------------------------------------------------
`default_nettype none

module tpfg_limits (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       restart,
  input  wire logic [tpfg_pkg::MAX_W-1:0] max_asdu_size,
  input  wire logic [tpfg_pkg::IO_W-1:0]  io_size,
  output tpfg_pkg::lim_t                  lim,
  output logic                            busy
);
  import tpfg_pkg::*;

  logic              armed;
  logic [STEP_W-1:0] step;
  logic [MAX_W-1:0]  seq_limit;
  logic [IO_W-1:0]   rem;
  logic [IO_W-1:0]   den;
  logic [MAX_W-1:0]  nq;
  logic              tiny;

  logic [MAX_W-1:0]  num_v;
  logic [IO_W-1:0]   den_v;
  logic              tiny_v;
  logic [IO_W:0]     trial;
  logic              ge;
  logic [IO_W-1:0]   rem_next;
  logic [MAX_W-1:0]  nq_next;

  always_comb begin
    tiny_v = ({1'b0, max_asdu_size} <= (9'(HDR_BYTES) + {2'b0, io_size}));
    num_v  = 8'({1'b0, max_asdu_size} - 9'(HDR_BYTES) - {2'b0, io_size});
    den_v  = (io_size <= IO_W'(ADDR_BYTES)) ? IO_W'(1) : io_size - IO_W'(ADDR_BYTES);
    // restoring division, one quotient bit per cycle
    trial    = {rem, nq[MAX_W-1]};
    ge       = (trial >= {1'b0, den});
    rem_next = ge ? IO_W'(trial - {1'b0, den}) : trial[IO_W-1:0];
    nq_next  = {nq[MAX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      step      <= '0;
      seq_limit <= MAX_W'(SEQ_LIMIT_RST);
    end else begin
      armed <= restart;
      if (armed) begin
        step <= STEP_W'(DIV_STEPS);
      end else if (step != '0) begin
        step <= step - 1'b1;
        if (step == STEP_W'(1)) begin
          seq_limit <= tiny ? MAX_W'(1) : nq_next + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (armed) begin
      rem  <= '0;
      nq   <= num_v;
      den  <= den_v;
      tiny <= tiny_v;
    end else if (step != '0) begin
      rem <= rem_next;
      nq  <= nq_next;
    end
  end

  // plain frames take two objects only if both fit
  assign lim.plain_single = (io_size == '0) ||
                            ({1'b0, max_asdu_size} < (9'(HDR_BYTES) + {1'b0, io_size, 1'b0}));
  assign lim.seq_limit    = seq_limit;
  assign busy             = armed || (step != '0);

endmodule

`default_nettype wire

FILE: rtl/core/tpfg_group.sv
// ---------------------------------------------------------------------------
// tpfg_group
// run tracking state and the per-item grouping decision, up to three objects out
// ---------------------------------------------------------------------------
`default_nettype none

module tpfg_group #(
  parameter int MAX_POINTS = tpfg_pkg::MAX_POINTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [tpfg_pkg::ADDR_W-1:0] ioa,
  input  wire logic                        end_of_list,
  input  wire tpfg_pkg::lim_t              lim,
  output tpfg_pkg::batch_t                 batch
);
  import tpfg_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_POINTS - 1);

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] v);
    return (v == IDX_LAST) ? '0 : v + 1'b1;
  endfunction

  logic [ADDR_W-1:0] held0, held0_next;
  logic [ADDR_W-1:0] held1, held1_next;
  logic [1:0]        held_cnt, held_cnt_next;
  logic [ADDR_W-1:0] prev, prev_next;
  logic              run, run_next;
  logic [MAX_W-1:0]  fill, fill_next;
  logic [IW-1:0]     next_idx, next_idx_next;

  logic              cont;
  logic              single;
  seq_mark_t         m0, m1, m2;
  logic [1:0]        n;
  logic [IW-1:0]     idx [SLOTS+1];
  batch_t            bat;

  always_comb begin
    cont   = (held_cnt != 2'd0) && (prev != '1) && (ioa == prev + 1'b1);
    single = lim.plain_single;
    m0     = '0;
    m1     = '0;
    m2     = '0;
    n      = 2'd0;
    bat    = '0;

    held0_next    = held0;
    held1_next    = held1;
    held_cnt_next = held_cnt;
    run_next      = run;
    fill_next     = fill;

    if (run) begin
      m0          = seq_mark(fill, !cont, lim.seq_limit);
      fill_next   = m0.fill_next;
      bat.slot[0] = mk_result(held0, 1'b1, m0.first, m0.last);
      n           = 2'd1;
      held0_next    = ioa;
      held_cnt_next = 2'd1;
      if (cont) begin
        if (end_of_list) begin
          m1          = seq_mark(m0.fill_next, 1'b1, lim.seq_limit);
          fill_next   = m1.fill_next;
          bat.slot[1] = mk_result(ioa, 1'b1, m1.first, m1.last);
          n           = 2'd2;
        end
      end else begin
        run_next = 1'b0;
        if (end_of_list) begin
          bat.slot[1] = mk_result(ioa, 1'b0, 1'b1, 1'b1);
          n           = 2'd2;
        end
      end
    end else if (cont && (held_cnt == 2'd1)) begin
      held1_next    = ioa;
      held_cnt_next = 2'd2;
      if (end_of_list) begin
        bat.slot[0] = mk_result(held0, 1'b0, 1'b1, single);
        bat.slot[1] = mk_result(ioa, 1'b0, single, 1'b1);
        n           = 2'd2;
      end
    end else if (cont) begin
      // third object of a run: open sequence mode
      run_next    = 1'b1;
      m0          = seq_mark('0, 1'b0, lim.seq_limit);
      m1          = seq_mark(m0.fill_next, 1'b0, lim.seq_limit);
      fill_next   = m1.fill_next;
      bat.slot[0] = mk_result(held0, 1'b1, m0.first, m0.last);
      bat.slot[1] = mk_result(held1, 1'b1, m1.first, m1.last);
      n           = 2'd2;
      held0_next    = ioa;
      held_cnt_next = 2'd1;
      if (end_of_list) begin
        m2          = seq_mark(m1.fill_next, 1'b1, lim.seq_limit);
        fill_next   = m2.fill_next;
        bat.slot[2] = mk_result(ioa, 1'b1, m2.first, m2.last);
        n           = 2'd3;
      end
    end else begin
      // run broken: flush the short run as plain frames
      held0_next    = ioa;
      held_cnt_next = 2'd1;
      unique case (held_cnt)
        2'd0: begin
          if (end_of_list) begin
            bat.slot[0] = mk_result(ioa, 1'b0, 1'b1, 1'b1);
            n           = 2'd1;
          end
        end
        2'd1: begin
          bat.slot[0] = mk_result(held0, 1'b0, 1'b1, 1'b1);
          n           = 2'd1;
          if (end_of_list) begin
            bat.slot[1] = mk_result(ioa, 1'b0, 1'b1, 1'b1);
            n           = 2'd2;
          end
        end
        default: begin
          bat.slot[0] = mk_result(held0, 1'b0, 1'b1, single);
          bat.slot[1] = mk_result(held1, 1'b0, single, 1'b1);
          n           = 2'd2;
          if (end_of_list) begin
            bat.slot[2] = mk_result(ioa, 1'b0, 1'b1, 1'b1);
            n           = 2'd3;
          end
        end
      endcase
    end

    idx[0] = next_idx;
    for (int k = 1; k <= SLOTS; k++) begin
      idx[k] = idx_inc(idx[k-1]);
    end
    for (int k = 0; k < SLOTS; k++) begin
      bat.slot[k].point_index = IDX_OUT_W'(idx[k]);
      bat.slot[k].results_end = (2'(k + 1) == n);
    end
    bat.cnt = n;

    unique case (n)
      2'd0:    next_idx_next = idx[0];
      2'd1:    next_idx_next = idx[1];
      2'd2:    next_idx_next = idx[2];
      default: next_idx_next = idx[3];
    endcase

    prev_next = ioa;
    if (end_of_list) begin
      held_cnt_next = 2'd0;
      prev_next     = '0;
      run_next      = 1'b0;
      fill_next     = '0;
      next_idx_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt <= 2'd0;
      prev     <= '0;
      run      <= 1'b0;
      fill     <= '0;
      next_idx <= '0;
    end else if (take) begin
      held_cnt <= held_cnt_next;
      prev     <= prev_next;
      run      <= run_next;
      fill     <= fill_next;
      next_idx <= next_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held0 <= held0_next;
      held1 <= held1_next;
    end
  end

  assign batch = bat;

endmodule

`default_nettype wire

FILE: rtl/core/telemetry_point_frame_grouper.sv
// ---------------------------------------------------------------------------
// telemetry_point_frame_grouper
// groups a list of object addresses into sequence-mode and plain frames
// ---------------------------------------------------------------------------
// usage
//   s_* channel: one configured point per transfer, address in s_tdata,
//   s_tlast marks the last point of the list and flushes everything held
//   m_* channel: one placed object per transfer; an input transfer causes
//   zero to three of them, the last one flagged by results_end
//   cfg_*: register 0 max_asdu_size, register 1 io_size, written while idle
// output timing and input flow
//   results of a transfer show on m_* in the cycle after it is taken; a new
//   point is taken when the limits are idle and no result is waiting, or
//   when one is waiting and leaves in that cycle, so the input waits while
//   the results of a point drain through the single result channel
//   a config write runs the sequence limit divider, during which s_tready
//   stays low
// reset and stall
//   rst clears run state, the list index and the output queue, and restores
//   the register defaults with their precomputed limits; no clearing pass
//   when m_tready is low, results wait in the three-entry output queue and
//   s_tready stays low while any of them is pending
// ---------------------------------------------------------------------------
`default_nettype none

module telemetry_point_frame_grouper #(
  parameter int MAX_POINTS = tpfg_pkg::MAX_POINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [tpfg_pkg::ADDR_W-1:0]      s_tdata,   // ioa[23:0]
  input  wire logic                             s_tlast,   // end_of_list
  // result stream
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [tpfg_pkg::OUT_TDATA_W-1:0]      m_tdata,   // ioa_res[23:0], point_index[39:24],
                                                           // first_in_frame[40], results_end[41]
  output logic                                  m_tuser,   // sequence_mode
  output logic                                  m_tlast,   // last_in_frame
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [tpfg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [tpfg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tpfg_pkg::*;

`include "telemetry_point_frame_grouper_defines.svh"

  logic [MAX_W-1:0] max_asdu_size;
  logic [IO_W-1:0]  io_size;

  lim_t              lim;
  logic              lim_busy;
  batch_t            batch;
  logic              take;
  logic              pop;

  // output queue, entry 0 is on the port
  result_t [SLOTS-1:0] obuf_slot;
  logic    [1:0]       ocnt;
  result_t             head;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_asdu_size <= MAX_W'(MAX_ASDU_RST);
      io_size       <= IO_W'(IO_SIZE_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_ASDU: max_asdu_size <= cfg_wdata;
        REG_IO_SIZE:  io_size       <= cfg_wdata[IO_W-1:0];
      endcase
    end
  end

  tpfg_limits u_limits (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_we),
    .max_asdu_size (max_asdu_size),
    .io_size       (io_size),
    .lim           (lim),
    .busy          (lim_busy)
  );

  // take a point when the limits are idle and the queue will be empty by the next edge
  assign s_tready = !lim_busy && ((ocnt == 2'd0) || ((ocnt == 2'd1) && m_tready));
  assign take     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;

  tpfg_group #(
    .MAX_POINTS (MAX_POINTS)
  ) u_group (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .ioa         (s_tdata),
    .end_of_list (s_tlast),
    .lim         (lim),
    .batch       (batch)
  );

  // queue count
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else if (take) begin
      ocnt <= batch.cnt;
    end else if (pop) begin
      ocnt <= ocnt - 1'b1;
    end
  end

  // queue payload, shifts toward entry 0 as results leave
  always_ff @(posedge clk) begin
    if (take) begin
      obuf_slot <= batch.slot;
    end else if (pop) begin
      obuf_slot[0] <= obuf_slot[1];
      obuf_slot[1] <= obuf_slot[2];
    end
  end

  assign head     = obuf_slot[0];
  assign m_tvalid = (ocnt != 2'd0);
  assign m_tdata  = {6'b0, head.results_end, head.first_in_frame,
                     head.point_index, head.ioa_res};
  assign m_tuser  = head.sequence_mode;
  assign m_tlast  = head.last_in_frame;

  // no point taken while the limits are being recomputed
  `TPFG_ASSERT_NOW(a_hold_while_div, lim_busy, !s_tready)
  // a point that yields objects shows one on the port next cycle
  `TPFG_ASSERT_NEXT(a_load_shows, take && (batch.cnt != 2'd0), m_tvalid)
  // an object that is not the last of its point has a successor queued
  `TPFG_ASSERT_NOW(a_end_marks_tail, (ocnt != 2'd0) && !head.results_end, ocnt >= 2'd2)

endmodule

`default_nettype wire
